// ===== rtl/isq_pkg.sv =====
`default_nettype none

package isq_pkg;

   // storage depth and derived widths
   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int INDEX_W = 7;
   localparam int LEN_W   = 7;
   localparam int DATA_W  = 32;
   localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   // read tree: groups of eight cells, then one pick among the groups
   localparam int GRP_W = 3;
   localparam int GRP   = 2 ** GRP_W;
   localparam int RA_W  = (ADDR_W < GRP_W + 1) ? GRP_W + 1 : ADDR_W;
   localparam int HI_W  = RA_W - GRP_W;
   localparam int NGRP  = 2 ** HI_W;

   typedef enum logic [1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_GET     = 2'd1,
      FUNC_REMOVE  = 2'd2,
      FUNC_REVERSE = 2'd3
   } func_type;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      func_type             func;
      logic [INDEX_W-1:0]   index;
      data_type             value;
   } req_type;

   typedef struct packed {
      logic               ok;
      data_type           read_value;
      logic [LEN_W-1:0]   length;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD      = 2'd0,
      CELL_LOAD      = 2'd1,
      CELL_FROM_LOW  = 2'd2,
      CELL_FROM_HIGH = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic              load;
      logic [RA_W-1:0]   addr;
   } rd_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/indexed_sequence_store.sv =====
// Ordered store of up to DEPTH signed 32-bit entries held in a row of cells.
// Command channel: drive req (func, index, value) and raise start; the
// transfer happens at the clock edge where start is high and busy is low.
// Operations: insert at a position, get, remove, reverse the order.
// Result channel: rsp (ok, read_value, length) is valid for exactly one
// cycle while rsp_strobe is high; the receiver has no way to hold it off.
// After the command transfer, the decode step checks the command against the
// count and moves at once every cell at or above the slot (shift toward the
// back on insert, toward the front on remove; reverse only flips a direction
// bit) and loads the first level of the read tree (a cell within each group
// of eight). The pick step then selects the group into the result register;
// the strobe register is set at the same edge. busy covers the decode and
// pick steps, so a new command waits until the previous one is past them,
// and its transfer may share an edge with the previous result.
// Reset: count and direction clear, the store reads as empty; cell contents
// are left as they are and are never shown before being written.
`default_nettype none

module indexed_sequence_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  isq_pkg::req_type req,
   output logic             rsp_strobe,
   output isq_pkg::rsp_type rsp
);

   isq_pkg::req_type               req_ff;
   logic                           s1_ff;
   logic                           s2_ff;
   logic [isq_pkg::CNT_W-1:0]      count_ff;
   logic [isq_pkg::CNT_W-1:0]      count_in;
   logic                           reversed_ff;
   logic                           reversed_in;
   logic                           ok_ff;
   logic                           get_ff;
   logic                           rsp_strobe_ff;
   isq_pkg::rsp_type               rsp_ff;

   logic                           ok;
   logic [isq_pkg::CMP_W-1:0]      pos;
   logic [isq_pkg::CMP_W-1:0]      cnt;
   logic [isq_pkg::CMP_W-1:0]      slot;
   logic                           full;
   logic                           accept;
   isq_pkg::cell_op_type           cell_op [isq_pkg::DEPTH];
   isq_pkg::data_type              cell_value [isq_pkg::DEPTH];
   isq_pkg::rd_ctrl_type           rd_ctrl;
   isq_pkg::data_type              rd_data;

   assign accept = start && !busy;
   assign busy   = s1_ff || s2_ff;

   // hold the command for the decode cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   // decode against the count and map the position to a cell
   always_comb begin
      pos  = isq_pkg::CMP_W'(req_ff.index);
      cnt  = isq_pkg::CMP_W'(count_ff);
      full = (count_ff == isq_pkg::CNT_W'(isq_pkg::DEPTH));
      unique case (req_ff.func)
         isq_pkg::FUNC_INSERT: begin
            ok   = !full && (pos <= cnt);
            slot = reversed_ff ? (cnt - pos) : pos;
         end
         isq_pkg::FUNC_GET, isq_pkg::FUNC_REMOVE: begin
            ok   = (pos < cnt);
            slot = reversed_ff ? (cnt - isq_pkg::CMP_W'(1) - pos) : pos;
         end
         isq_pkg::FUNC_REVERSE: begin
            ok   = (cnt != '0);
            slot = pos;
         end
         default: begin
            ok   = 1'b0;
            slot = pos;
         end
      endcase
   end

   // advance count and direction
   always_comb begin
      count_in    = count_ff;
      reversed_in = reversed_ff;
      if (s1_ff && ok) begin
         unique case (req_ff.func)
            isq_pkg::FUNC_INSERT:  count_in = count_ff + isq_pkg::CNT_W'(1);
            isq_pkg::FUNC_REMOVE:  count_in = count_ff - isq_pkg::CNT_W'(1);
            isq_pkg::FUNC_REVERSE: reversed_in = !reversed_ff;
            isq_pkg::FUNC_GET:     count_in = count_ff;
            default:               count_in = count_ff;
         endcase
      end
   end

   // per-cell move: open a gap on insert, close it on remove
   always_comb begin
      for (int k = 0; k < isq_pkg::DEPTH; k++) begin
         cell_op[k] = isq_pkg::CELL_HOLD;
         if (s1_ff && ok) begin
            if (req_ff.func == isq_pkg::FUNC_INSERT) begin
               if (isq_pkg::CMP_W'(k) == slot) begin
                  cell_op[k] = isq_pkg::CELL_LOAD;
               end else if (isq_pkg::CMP_W'(k) > slot) begin
                  cell_op[k] = isq_pkg::CELL_FROM_LOW;
               end
            end else if (req_ff.func == isq_pkg::FUNC_REMOVE) begin
               if (isq_pkg::CMP_W'(k) >= slot) begin
                  cell_op[k] = isq_pkg::CELL_FROM_HIGH;
               end
            end
         end
      end
   end

   // row of cells, each linked to both neighbors
   for (genvar k = 0; k < isq_pkg::DEPTH; k++) begin : g_cell
      isq_pkg::data_type low_value;
      isq_pkg::data_type high_value;
      if (k == 0) begin : g_first
         assign low_value = '0;
      end else begin : g_low
         assign low_value = cell_value[k-1];
      end
      if (k == isq_pkg::DEPTH - 1) begin : g_last
         assign high_value = cell_value[k];
      end else begin : g_high
         assign high_value = cell_value[k+1];
      end
      isq_cell u_cell (
         .clock      (clock),
         .op         (cell_op[k]),
         .load_value (req_ff.value),
         .low_value  (low_value),
         .high_value (high_value),
         .value      (cell_value[k])
      );
   end

   assign rd_ctrl.load = s1_ff && (req_ff.func == isq_pkg::FUNC_GET);
   assign rd_ctrl.addr = isq_pkg::RA_W'(slot);

   isq_read u_read (
      .clock   (clock),
      .cells   (cell_value),
      .ctrl    (rd_ctrl),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= 1'b0;
         s2_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         reversed_ff   <= 1'b0;
      end else begin
         s1_ff         <= accept;
         s2_ff         <= s1_ff;
         rsp_strobe_ff <= s2_ff;
         count_ff      <= count_in;
         reversed_ff   <= reversed_in;
      end
   end

   // carry the outcome to the result register
   always_ff @(posedge clock) begin
      if (s1_ff) begin
         ok_ff  <= ok;
         get_ff <= (req_ff.func == isq_pkg::FUNC_GET);
      end
      if (s2_ff) begin
         rsp_ff.ok         <= ok_ff;
         rsp_ff.read_value <= (get_ff && ok_ff) ? rd_data : '0;
         rsp_ff.length     <= isq_pkg::LEN_W'(count_ff);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/isq_cell.sv =====
`default_nettype none

module isq_cell (
   input  logic                 clock,
   input  isq_pkg::cell_op_type op,
   input  isq_pkg::data_type    load_value,
   input  isq_pkg::data_type    low_value,
   input  isq_pkg::data_type    high_value,
   output isq_pkg::data_type    value
);

   isq_pkg::data_type value_ff;
   isq_pkg::data_type value_in;

   // hold, load a new entry, or take a neighbor's entry
   always_comb begin
      unique case (op)
         isq_pkg::CELL_HOLD:      value_in = value_ff;
         isq_pkg::CELL_LOAD:      value_in = load_value;
         isq_pkg::CELL_FROM_LOW:  value_in = low_value;
         isq_pkg::CELL_FROM_HIGH: value_in = high_value;
         default:                 value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/isq_read.sv =====
`default_nettype none

module isq_read (
   input  logic                 clock,
   input  isq_pkg::data_type    cells [isq_pkg::DEPTH],
   input  isq_pkg::rd_ctrl_type ctrl,
   output isq_pkg::data_type    rd_data
);

   isq_pkg::data_type              pad [isq_pkg::NGRP][isq_pkg::GRP];
   isq_pkg::data_type              group_ff [isq_pkg::NGRP];
   logic [isq_pkg::HI_W-1:0]       hi_ff;

   // pad the row out to whole groups
   for (genvar i = 0; i < isq_pkg::NGRP * isq_pkg::GRP; i++) begin : g_pad
      if (i < isq_pkg::DEPTH) begin : g_real
         assign pad[i / isq_pkg::GRP][i % isq_pkg::GRP] = cells[i];
      end else begin : g_fill
         assign pad[i / isq_pkg::GRP][i % isq_pkg::GRP] = '0;
      end
   end

   // first level: pick one cell in every group, hold the group select
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         for (int g = 0; g < isq_pkg::NGRP; g++) begin
            group_ff[g] <= pad[g][ctrl.addr[isq_pkg::GRP_W-1:0]];
         end
         hi_ff <= ctrl.addr[isq_pkg::RA_W-1:isq_pkg::GRP_W];
      end
   end

   // second level: pick the group
   assign rd_data = group_ff[hi_ff];

endmodule

`default_nettype wire

// ===== rtl/isq_check.sv =====
`default_nettype none

module isq_check (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input isq_pkg::req_type req,
   input logic             rsp_strobe,
   input isq_pkg::rsp_type rsp
);

   logic transfer;
   assign transfer = start && !busy;

   // a taken command locks out the next one
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      transfer |=> busy)
      else $error("busy not raised after command transfer");

   // every command yields its result after a fixed delay
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      transfer |-> ##3 rsp_strobe)
      else $error("result strobe missing three cycles after transfer");

   // results only come when nothing is in flight
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a refused command reads back zero
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp.ok) |-> (rsp.read_value == '0))
      else $error("nonzero read value on refused command");

   // length never exceeds the storage
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp.length) <= isq_pkg::DEPTH))
      else $error("reported length above depth");

endmodule

bind indexed_sequence_store isq_check u_isq_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

`default_nettype wire

// ===== tb/sv/indexed_sequence_store_test.sv =====
`timescale 1ns / 100ps

import isq_pkg::*;

// Shadow of the store: keeps its own cells, count and direction bit and
// lines up the response each accepted command must produce.
class sequence_scoreboard;
   data_type    cells[DEPTH];
   int unsigned fill;
   bit          flipped;
   rsp_type     expected_q[$];
   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned refusals;
   int unsigned full_refusals;
   int unsigned reversals;

   function new();
      fill = 0;
      flipped = 1'b0;
      mismatches = 0;
      results_checked = 0;
      refusals = 0;
      full_refusals = 0;
      reversals = 0;
   endfunction

   // apply one accepted command to the shadow and queue its response
   function void note_command(req_type cmd);
      rsp_type     want;
      int unsigned pos;
      int unsigned slot;
      pos = cmd.index;
      want = '0;
      case (cmd.func)
         FUNC_INSERT: begin
            if (fill < DEPTH && pos <= fill) begin
               slot = flipped ? fill - pos : pos;
               for (int unsigned k = fill; k > slot; k--)
                  cells[k] = cells[k-1];
               cells[slot] = cmd.value;
               fill++;
               want.ok = 1'b1;
            end else if (fill == DEPTH) begin
               full_refusals++;
            end
         end
         FUNC_GET: begin
            if (pos < fill) begin
               want.read_value = cells[flipped ? fill - 1 - pos : pos];
               want.ok = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (pos < fill) begin
               slot = flipped ? fill - 1 - pos : pos;
               for (int unsigned k = slot; k + 1 < fill; k++)
                  cells[k] = cells[k+1];
               fill--;
               want.ok = 1'b1;
            end
         end
         default: begin
            if (fill > 0) begin
               flipped = !flipped;
               reversals++;
               want.ok = 1'b1;
            end
         end
      endcase
      if (!want.ok)
         refusals++;
      want.length = LEN_W'(fill);
      expected_q.push_back(want);
   endfunction

   // compare one response against the oldest queued expectation
   function void check_result(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: response with none expected: ok=%0b read_value=%0d length=%0d",
                  $time, got.ok, got.read_value, got.length);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.ok !== want.ok) begin
         $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
         mismatches++;
      end
      if (got.read_value !== want.read_value) begin
         $display("%0t: read_value mismatch: expected %0d, actual %0d",
                  $time, want.read_value, got.read_value);
         mismatches++;
      end
      if (got.length !== want.length) begin
         $display("%0t: length mismatch: expected %0d, actual %0d",
                  $time, want.length, got.length);
         mismatches++;
      end
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction
endclass

module indexed_sequence_store_test;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1330;
   localparam int SEGMENT      = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_strobe;
   rsp_type rsp;

   sequence_scoreboard board = new;
   int unsigned commands_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 0;

   indexed_sequence_store uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always #5 clock = ~clock;

   // observe transfers on both channels at each rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            board.check_result(rsp);
         if (start && !busy)
            board.note_command(req);
      end
   end

   // end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (rsp_strobe || (start && !busy))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type make_cmd(func_type op, int unsigned pos, data_type val);
      req_type cmd;
      cmd.func = op;
      cmd.index = INDEX_W'(pos);
      cmd.value = val;
      return cmd;
   endfunction

   // hold start low for one cycle
   task automatic idle_cycle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // present one command and wait for its transfer; start stays high after
   task automatic send_cmd(req_type cmd);
      while ($urandom_range(99) < idle_pct)
         idle_cycle();
      start <= 1'b1;
      req <= cmd;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      commands_sent++;
   endtask

   // hold off the sender until every queued response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0)
         @(posedge clock);
   endtask

   // random command, biased toward growing or shrinking the store
   function automatic req_type random_cmd(bit growing);
      func_type    op;
      int unsigned pick;
      int unsigned pos;
      data_type    val;
      pick = $urandom_range(99);
      if (growing)
         op = (pick < 65) ? FUNC_INSERT : (pick < 80) ? FUNC_GET :
              (pick < 90) ? FUNC_REMOVE : FUNC_REVERSE;
      else
         op = (pick < 10) ? FUNC_INSERT : (pick < 25) ? FUNC_GET :
              (pick < 90) ? FUNC_REMOVE : FUNC_REVERSE;
      pick = $urandom_range(99);
      if (pick < 50)
         pos = $urandom_range(board.fill);
      else if (pick < 60)
         pos = board.fill;
      else if (pick < 70)
         pos = (board.fill > 0) ? board.fill - 1 : 0;
      else if (pick < 78)
         pos = 127;
      else
         pos = $urandom_range(127);
      pick = $urandom_range(19);
      case (pick)
         0: val = 32'sh8000_0000;
         1: val = 32'sh7fff_ffff;
         2: val = '0;
         3: val = -32'sd1;
         default: val = data_type'($urandom);
      endcase
      return make_cmd(op, pos, val);
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store: every refusal, then build, flip and shrink a short list
      send_cmd(make_cmd(FUNC_GET, 0, 32'sd7));
      send_cmd(make_cmd(FUNC_REMOVE, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_REVERSE, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_INSERT, 1, 32'sd11));
      send_cmd(make_cmd(FUNC_INSERT, 127, 32'sd12));
      send_cmd(make_cmd(FUNC_INSERT, 0, 32'sh8000_0000));
      send_cmd(make_cmd(FUNC_INSERT, 1, 32'sh7fff_ffff));
      send_cmd(make_cmd(FUNC_INSERT, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_INSERT, 3, -32'sd1));
      send_cmd(make_cmd(FUNC_GET, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 3, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 4, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 127, 32'sd0));
      send_cmd(make_cmd(FUNC_REVERSE, 127, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_INSERT, 0, 32'sd5555));
      send_cmd(make_cmd(FUNC_INSERT, 5, -32'sd5555));
      send_cmd(make_cmd(FUNC_GET, 5, 32'sd0));
      send_cmd(make_cmd(FUNC_REMOVE, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_REMOVE, 3, 32'sd0));
      send_cmd(make_cmd(FUNC_REMOVE, 127, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 1, 32'sd0));
      send_cmd(make_cmd(FUNC_REVERSE, 0, 32'sd0));
      send_cmd(make_cmd(FUNC_GET, 0, 32'sd0));
      drain_responses();

      // random traffic over four sender pacing phases
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n * 4) / RANDOM_ITEMS)
            0: idle_pct = 0;
            1: idle_pct = 56;
            2: idle_pct = 30;
            default: idle_pct = 0;
         endcase
         if (n % 200 == 100)
            drain_responses();
         send_cmd(random_cmd(((n / SEGMENT) % 2) == 0));
      end

      drain_responses();
      repeat (8) @(posedge clock);

      $display("%0d commands sent, %0d responses checked, %0d refused",
               commands_sent, board.results_checked, board.refusals);
      $display("inserts refused on a full store: %0d, successful reversals: %0d",
               board.full_refusals, board.reversals);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== indexed_sequence_store.f =====
rtl/isq_pkg.sv
rtl/isq_cell.sv
rtl/isq_read.sv
rtl/indexed_sequence_store.sv
rtl/isq_check.sv
tb/sv/indexed_sequence_store_test.sv
